>>> hdl/stmam_pkg.sv
package stmam_pkg;

  // item field widths
  localparam int ACTION_W = 3;
  localparam int POS_W    = 3;
  localparam int VALUE_W  = 16;
  localparam int SIZE_W   = 4;
  localparam int STATUS_W = 2;
  localparam int SUM_W    = 24;
  localparam int PROD_W   = 44;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_A  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LOAD_B  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_COMPUTE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ    = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OOR  = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // controller to datapath
  typedef struct packed {
    logic take;       // input request accepted this cycle
    logic rd_issue;   // read stores at the requested position
    logic rd_out;     // load result register from store read
    logic clr_store;  // drop all sum and product entries
    logic i_rst;
    logic i_inc;
    logic j_rst;
    logic j_inc;
    logic sel_b;      // sum pass walks the b list
    logic list_rd;    // read triplets at the counters
    logic sum_rd;     // read sum entry of current triplet
    logic sum_wr;     // write back accumulated sum
    logic pair_chk;   // multiply pair and read product entry
    logic prod_wr;    // write back accumulated product
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic is_read;
    logic is_compute;
    logic a_empty;
    logic b_empty;
    logic i_last;
    logic j_last;
    logic match;
  } dp_stat_t;

endpackage

>>> hdl/sparse_triplet_matrix_add_mul.sv
// sparse triplet matrix adder and multiplier: two square matrices a and b are
// held as lists of (row, col, value) triplets, MAX_TERMS each. a request
// carries an action: clear lists, load a, load b, compute, or read. every
// request returns exactly one result (status, sum, product). on a load a zero
// value is accepted but not stored, a position at or beyond the size register
// gives status 2, a full list status 1. a read passes through the registered
// read port of the dense stores before the result register. a compute
// request returns its result at once and then holds off input while the
// sequencer walks the lists through one shared multiplier and one store
// port each: one pass sums each triplet of a and b, then each triplet pair is
// checked, and multiplied and accumulated where a.col matches b.row.
// the stores start at zero after reset and are cleared at the start of every
// compute by per-entry valid flags, so no clearing pass is needed.
// matrix_size may be written at any time the block is idle; values above
// MAX_DIM are limited to MAX_DIM.
module sparse_triplet_matrix_add_mul #(
  parameter int MAX_DIM    = 8,
  parameter int MAX_TERMS  = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request: action[2:0], row[5:3], col[8:6], value[24:9], zero fill above
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [stmam_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // result: status[1:0], sum_value[25:2], product_value[69:26], zero fill above
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [stmam_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // matrix_size write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [stmam_pkg::SIZE_W-1:0]       cfg_data_i
);
  import stmam_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // the size register is always writable
  assign cfg_ready_o = 1'b1;

  // sequencer for requests and the compute walk
  stmam_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // lists, dense stores, multiplier and result register
  stmam_dp #(
    .MAX_DIM    (MAX_DIM),
    .MAX_TERMS  (MAX_TERMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .s_tdata_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // a request is only taken when the result register can accept its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("request taken while result register blocked");

  // non-read requests present their result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[ACTION_W-1:0] != ACT_READ)
    |=> m_axis_tvalid)
    else $error("missing result after non-read request");

  // read requests present their result after the store read and the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[ACTION_W-1:0] == ACT_READ)
    |-> ##2 m_axis_tvalid)
    else $error("missing result after read request");

  // in the cycle after a read request the input is closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[ACTION_W-1:0] == ACT_READ)
    |=> !s_axis_tready)
    else $error("input open during read");
`endif

endmodule

>>> hdl/stmam_ctrl.sv
module stmam_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  stmam_pkg::dp_stat_t stat_i,
  output stmam_pkg::dp_cmd_t  cmd_o
);
  import stmam_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_CLR, ST_SUM_RD, ST_SUM_LK, ST_SUM_WR,
    ST_PR_RD, ST_PR_CHK, ST_PR_WR
  } state_e;

  state_e state_q, state_d;
  logic   phase_q, phase_d;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    phase_d   = phase_q;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o  = stat_i.out_free;
        cmd_o.take = s_valid_i && stat_i.out_free;
        if (cmd_o.take) begin
          if (stat_i.is_read) begin
            cmd_o.rd_issue = 1'b1;
            state_d        = ST_READ;
          end else if (stat_i.is_compute) begin
            state_d = ST_CLR;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_out = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_CLR: begin
        cmd_o.clr_store = 1'b1;
        cmd_o.i_rst     = 1'b1;
        cmd_o.j_rst     = 1'b1;
        if (!stat_i.a_empty) begin
          phase_d = 1'b0;
          state_d = ST_SUM_RD;
        end else if (!stat_i.b_empty) begin
          phase_d = 1'b1;
          state_d = ST_SUM_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM_RD: begin
        cmd_o.sel_b   = phase_q;
        cmd_o.list_rd = 1'b1;
        state_d       = ST_SUM_LK;
      end
      ST_SUM_LK: begin
        cmd_o.sel_b  = phase_q;
        cmd_o.sum_rd = 1'b1;
        state_d      = ST_SUM_WR;
      end
      ST_SUM_WR: begin
        cmd_o.sel_b  = phase_q;
        cmd_o.sum_wr = 1'b1;
        if (!stat_i.i_last) begin
          cmd_o.i_inc = 1'b1;
          state_d     = ST_SUM_RD;
        end else if (!phase_q && !stat_i.b_empty) begin
          cmd_o.i_rst = 1'b1;
          phase_d     = 1'b1;
          state_d     = ST_SUM_RD;
        end else if (!stat_i.a_empty && !stat_i.b_empty) begin
          cmd_o.i_rst = 1'b1;
          cmd_o.j_rst = 1'b1;
          phase_d     = 1'b0;
          state_d     = ST_PR_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PR_RD: begin
        cmd_o.list_rd = 1'b1;
        state_d       = ST_PR_CHK;
      end
      ST_PR_CHK, ST_PR_WR: begin
        if (state_q == ST_PR_CHK && stat_i.match) begin
          cmd_o.pair_chk = 1'b1;
          state_d        = ST_PR_WR;
        end else begin
          cmd_o.prod_wr = (state_q == ST_PR_WR);
          if (!stat_i.j_last) begin
            cmd_o.j_inc = 1'b1;
            state_d     = ST_PR_RD;
          end else if (!stat_i.i_last) begin
            cmd_o.i_inc = 1'b1;
            cmd_o.j_rst = 1'b1;
            state_d     = ST_PR_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

>>> hdl/stmam_dp.sv
module stmam_dp #(
  parameter int MAX_DIM    = 8,
  parameter int MAX_TERMS  = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  stmam_pkg::dp_cmd_t                    cmd_i,
  output stmam_pkg::dp_stat_t                   stat_o,
  input  logic [stmam_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  input  logic                                  cfg_valid_i,
  input  logic [stmam_pkg::SIZE_W-1:0]          cfg_data_i,
  input  logic                                  m_tready_i,
  output logic                                  m_tvalid_o,
  output logic [stmam_pkg::OUT_TDATA_W-1:0]     m_tdata_o
);
  import stmam_pkg::*;

  localparam int AW = $clog2(MAX_TERMS);
  localparam int LW = $clog2(MAX_TERMS + 1);
  localparam int NE = MAX_DIM * MAX_DIM;
  localparam int IW = $clog2(NE);
  localparam int TW = 2 * POS_W + VALUE_BITS;
  localparam int VZ = VALUE_BITS + VALUE_W;
  localparam int NW = ($clog2(MAX_DIM + 1) > SIZE_W) ? $clog2(MAX_DIM + 1) : SIZE_W;

  // unpack request
  logic [ACTION_W-1:0] in_action;
  logic [POS_W-1:0]    in_row, in_col;
  logic [VALUE_W-1:0]  in_value;
  assign in_action = s_tdata_i[ACTION_W-1:0];
  assign in_row    = s_tdata_i[ACTION_W+POS_W-1:ACTION_W];
  assign in_col    = s_tdata_i[ACTION_W+2*POS_W-1:ACTION_W+POS_W];
  assign in_value  = s_tdata_i[ACTION_W+2*POS_W+VALUE_W-1:ACTION_W+2*POS_W];

  logic [SIZE_W-1:0] size_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= SIZE_RESET;
    else if (cfg_valid_i) size_q <= cfg_data_i;
  end

  logic [NW-1:0] n_use;
  logic          oor;
  logic [IW-1:0] item_idx;
  logic [VZ-1:0] val_z;
  logic [VALUE_BITS-1:0] val_in;
  always_comb begin
    n_use    = (NW'(size_q) > NW'(MAX_DIM)) ? NW'(MAX_DIM) : NW'(size_q);
    oor      = (NW'(in_row) >= n_use) || (NW'(in_col) >= n_use);
    item_idx = IW'(in_row * MAX_DIM + in_col);
    val_z    = VZ'(in_value);
    val_in   = val_z[VALUE_BITS-1:0];
  end

  // triplet lists
  logic [TW-1:0] a_mem [MAX_TERMS];
  logic [TW-1:0] b_mem [MAX_TERMS];
  logic [TW-1:0] a_rd_q, b_rd_q;
  logic [LW-1:0] a_len_q, b_len_q;
  logic [AW-1:0] i_q, j_q, b_addr;
  logic          is_load, load_a, load_b, list_full, a_we, b_we;
  logic [STATUS_W-1:0] load_status;
  logic [TW-1:0] new_trip;

  always_comb begin
    load_a    = (in_action == ACT_LOAD_A);
    load_b    = (in_action == ACT_LOAD_B);
    is_load   = load_a || load_b;
    list_full = load_a ? (a_len_q == LW'(MAX_TERMS)) : (b_len_q == LW'(MAX_TERMS));
    if (is_load && oor)            load_status = STAT_OOR;
    else if (is_load && list_full) load_status = STAT_FULL;
    else                           load_status = STAT_OK;
    a_we     = cmd_i.take && load_a && !oor && !list_full && (val_in != '0);
    b_we     = cmd_i.take && load_b && !oor && !list_full && (val_in != '0);
    new_trip = {val_in, in_col, in_row};
    b_addr   = cmd_i.sel_b ? i_q : j_q;
  end

  always_ff @(posedge clk_i) begin
    if (a_we) a_mem[a_len_q[AW-1:0]] <= new_trip;
    if (b_we) b_mem[b_len_q[AW-1:0]] <= new_trip;
    if (cmd_i.list_rd) begin
      a_rd_q <= a_mem[i_q];
      b_rd_q <= b_mem[b_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_len_q <= '0;
      b_len_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      if (cmd_i.take && in_action == ACT_CLEAR) begin
        a_len_q <= '0;
        b_len_q <= '0;
      end
      if (a_we) a_len_q <= a_len_q + LW'(1);
      if (b_we) b_len_q <= b_len_q + LW'(1);
      if (cmd_i.i_rst)      i_q <= '0;
      else if (cmd_i.i_inc) i_q <= i_q + AW'(1);
      if (cmd_i.j_rst)      j_q <= '0;
      else if (cmd_i.j_inc) j_q <= j_q + AW'(1);
    end
  end

  // triplet fields
  logic [TW-1:0] trip;
  logic signed [VALUE_BITS-1:0] trip_v, a_v, b_v;
  logic [IW-1:0] trip_idx, pair_idx;
  logic signed [2*VALUE_BITS-1:0] mul_full;
  always_comb begin
    trip     = cmd_i.sel_b ? b_rd_q : a_rd_q;
    trip_v   = $signed(trip[TW-1:2*POS_W]);
    trip_idx = IW'(trip[POS_W-1:0] * MAX_DIM + trip[2*POS_W-1:POS_W]);
    a_v      = $signed(a_rd_q[TW-1:2*POS_W]);
    b_v      = $signed(b_rd_q[TW-1:2*POS_W]);
    pair_idx = IW'(a_rd_q[POS_W-1:0] * MAX_DIM + b_rd_q[2*POS_W-1:POS_W]);
    mul_full = a_v * b_v;
  end

  // dense result stores
  logic [SUM_W-1:0]  sum_mem  [NE];
  logic [PROD_W-1:0] prod_mem [NE];
  logic [NE-1:0]     sum_vld_q, prod_vld_q;
  logic [IW-1:0]     sum_addr, prod_addr, sacc_idx_q, pacc_idx_q;
  logic [SUM_W-1:0]  sum_rdata_q, sacc_add_q;
  logic [PROD_W-1:0] prod_rdata_q, mul_q;
  logic              sum_rvld_q, prod_rvld_q;
  logic [SUM_W-1:0]  sum_new;
  logic [PROD_W-1:0] prod_new;

  always_comb begin
    sum_addr  = cmd_i.rd_issue ? item_idx : trip_idx;
    prod_addr = cmd_i.rd_issue ? item_idx : pair_idx;
    sum_new   = (sum_rvld_q ? sum_rdata_q : '0) + sacc_add_q;
    prod_new  = (prod_rvld_q ? prod_rdata_q : '0) + mul_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue || cmd_i.sum_rd) begin
      sum_rdata_q <= sum_mem[sum_addr];
      sum_rvld_q  <= sum_vld_q[sum_addr];
    end
    if (cmd_i.rd_issue || cmd_i.pair_chk) begin
      prod_rdata_q <= prod_mem[prod_addr];
      prod_rvld_q  <= prod_vld_q[prod_addr];
    end
    if (cmd_i.sum_rd) begin
      sacc_idx_q <= trip_idx;
      sacc_add_q <= SUM_W'(trip_v);
    end
    if (cmd_i.pair_chk) begin
      pacc_idx_q <= pair_idx;
      mul_q      <= PROD_W'(mul_full);
    end
    if (cmd_i.sum_wr)  sum_mem[sacc_idx_q]  <= sum_new;
    if (cmd_i.prod_wr) prod_mem[pacc_idx_q] <= prod_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q  <= '0;
      prod_vld_q <= '0;
    end else if (cmd_i.clr_store) begin
      sum_vld_q  <= '0;
      prod_vld_q <= '0;
    end else begin
      if (cmd_i.sum_wr)  sum_vld_q[sacc_idx_q]  <= 1'b1;
      if (cmd_i.prod_wr) prod_vld_q[pacc_idx_q] <= 1'b1;
    end
  end

  // result register
  logic                out_valid_q, rd_oor_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SUM_W-1:0]    out_sum_q;
  logic [PROD_W-1:0]   out_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.take && in_action != ACT_READ) || cmd_i.rd_out) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) rd_oor_q <= oor;
    if (cmd_i.take && in_action != ACT_READ) begin
      out_status_q <= load_status;
      out_sum_q    <= '0;
      out_prod_q   <= '0;
    end else if (cmd_i.rd_out) begin
      out_status_q <= rd_oor_q ? STAT_OOR : STAT_OK;
      out_sum_q    <= (!rd_oor_q && sum_rvld_q) ? sum_rdata_q : '0;
      out_prod_q   <= (!rd_oor_q && prod_rvld_q) ? prod_rdata_q : '0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = OUT_TDATA_W'({out_prod_q, out_sum_q, out_status_q});

  always_comb begin
    stat_o.out_free   = !out_valid_q || m_tready_i;
    stat_o.is_read    = (in_action == ACT_READ);
    stat_o.is_compute = (in_action == ACT_COMPUTE);
    stat_o.a_empty    = (a_len_q == '0);
    stat_o.b_empty    = (b_len_q == '0);
    stat_o.i_last     = cmd_i.sel_b ? (LW'(i_q) + LW'(1) == b_len_q)
                                    : (LW'(i_q) + LW'(1) == a_len_q);
    stat_o.j_last     = (LW'(j_q) + LW'(1) == b_len_q);
    stat_o.match      = (a_rd_q[2*POS_W-1:POS_W] == b_rd_q[POS_W-1:0]);
  end

endmodule

>>> dv/tb.sv
module tb;
  import stmam_pkg::*;

  localparam int MAX_DIM    = 8;
  localparam int MAX_TERMS  = 64;
  localparam int STALL_LIMIT = 100000;

  // actions the block ignores
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [SUM_W-1:0]  sum_value;
    logic signed [PROD_W-1:0] product_value;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0]          r;
    logic [POS_W-1:0]          c;
    logic signed [VALUE_W-1:0] v;
  } triplet_t;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [POS_W-1:0]    r;
    logic [POS_W-1:0]    c;
    logic [VALUE_W-1:0]  v;
    bit                  typed;
    result_t             res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [SIZE_W-1:0] cfg_data_i = '0;

  sparse_triplet_matrix_add_mul uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the matrices
  triplet_t              a_list[MAX_TERMS];
  triplet_t              b_list[MAX_TERMS];
  int unsigned           a_len, b_len;
  logic [SUM_W-1:0]      sum_mem[MAX_DIM*MAX_DIM];
  logic [PROD_W-1:0]     prod_mem[MAX_DIM*MAX_DIM];
  logic [SIZE_W-1:0]     size_reg;
  int unsigned           busy_cycles;

  result_t pending_results[$];
  int      errors = 0;
  int      idle_cycles = 0;
  int      burst_left = 0;
  int      items_sent = 0;
  int      cyc = 0;

  function automatic result_t predict_request(input logic [IN_TDATA_W-1:0] d);
    logic [ACTION_W-1:0] act;
    logic [POS_W-1:0]    r, c;
    logic signed [VALUE_W-1:0] v;
    int unsigned n;
    result_t res;
    act = d[2:0];
    r   = d[5:3];
    c   = d[8:6];
    v   = d[24:9];
    n   = (size_reg > MAX_DIM) ? MAX_DIM : size_reg;
    res = '0;
    case (act)
      ACT_CLEAR: begin
        a_len = 0;
        b_len = 0;
      end
      ACT_LOAD_A, ACT_LOAD_B: begin
        if (r >= n || c >= n) begin
          res.status = STAT_OOR;
        end else if (((act == ACT_LOAD_A) ? a_len : b_len) >= MAX_TERMS) begin
          res.status = STAT_FULL;
        end else if (v != 0) begin
          if (act == ACT_LOAD_A) begin
            a_list[a_len] = '{r, c, v};
            a_len++;
          end else begin
            b_list[b_len] = '{r, c, v};
            b_len++;
          end
        end
      end
      ACT_COMPUTE: begin
        foreach (sum_mem[k]) begin
          sum_mem[k]  = '0;
          prod_mem[k] = '0;
        end
        for (int i = 0; i < a_len; i++)
          sum_mem[a_list[i].r*MAX_DIM + a_list[i].c] += SUM_W'(a_list[i].v);
        for (int j = 0; j < b_len; j++)
          sum_mem[b_list[j].r*MAX_DIM + b_list[j].c] += SUM_W'(b_list[j].v);
        for (int i = 0; i < a_len; i++)
          for (int j = 0; j < b_len; j++)
            if (a_list[i].c == b_list[j].r)
              prod_mem[a_list[i].r*MAX_DIM + b_list[j].c] +=
                PROD_W'(longint'(a_list[i].v) * longint'(b_list[j].v));
        busy_cycles = 2 + 3*(a_len + b_len) + 3*a_len*b_len;
      end
      ACT_READ: begin
        if (r >= n || c >= n) begin
          res.status = STAT_OOR;
        end else begin
          res.sum_value     = sum_mem[r*MAX_DIM + c];
          res.product_value = prod_mem[r*MAX_DIM + c];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // one request: drive, wait for acceptance, then maybe open a gap
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] r,
                              input logic [POS_W-1:0] c, input logic [VALUE_W-1:0] v,
                              input bit typed = 0, input result_t typed_res = '0);
    logic [IN_TDATA_W-1:0] d;
    result_t res;
    d = '0;
    d[24:0] = {v, c, r, act};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    res = predict_request(d);
    pending_results.push_back(typed ? typed_res : res);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      // about one burst in four is long with no gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 20);
    end
  endtask

  // drain all results, then let a running compute pass finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (busy_cycles + 16) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] sz);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sz;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    size_reg = sz;
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return VALUE_W'($urandom_range(1, 9));
      3: return -VALUE_W'($urandom_range(1, 9));
      4: return '0;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // positions mostly inside the size in use, some anywhere
  function automatic logic [POS_W-1:0] rand_pos();
    int unsigned n;
    n = (size_reg > MAX_DIM) ? MAX_DIM : size_reg;
    if (n == 0 || $urandom_range(0, 7) == 0) return POS_W'($urandom_range(0, 7));
    return POS_W'($urandom_range(0, n - 1));
  endfunction

  // well-formed sequence: clear (most of the time), load both lists, compute, read back
  task automatic run_sequence(input int n_a, input int n_b, input int n_rd);
    if ($urandom_range(0, 3) != 0) send_request(ACT_CLEAR, rand_pos(), rand_pos(), rand_value());
    for (int i = 0; i < n_a; i++) send_request(ACT_LOAD_A, rand_pos(), rand_pos(), rand_value());
    for (int i = 0; i < n_b; i++) send_request(ACT_LOAD_B, rand_pos(), rand_pos(), rand_value());
    send_request(ACT_COMPUTE, rand_pos(), rand_pos(), rand_value());
    for (int i = 0; i < n_rd; i++) send_request(ACT_READ, rand_pos(), rand_pos(), rand_value());
  endtask

  task automatic random_phase(input int target, input bit fill);
    int stop_at;
    stop_at = items_sent + target;
    if (fill) run_sequence(70, 70, 20);
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(ACTION_W'($urandom_range(0, 7)), POS_W'($urandom),
                     POS_W'($urandom), VALUE_W'($urandom));
      end else begin
        run_sequence($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(2, 12));
      end
    end
  endtask

  // result checking against the oldest expectation
  always @(posedge clk_i) begin
    result_t got, want;
    cyc <= cyc + 1;
    // stall pattern: windows of full rate and windows of heavy back-pressure
    case ((cyc >> 8) & 3)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 2) == 0);
      default: m_axis_tready <= ((cyc & 7) < 5);
    endcase
    if (m_axis_tvalid && m_axis_tready) begin
      got.status        = m_axis_tdata[1:0];
      got.sum_value     = m_axis_tdata[25:2];
      got.product_value = m_axis_tdata[69:26];
      if (pending_results.size() == 0) begin
        $error("result with none pending: status %0d sum %0d product %0d",
               got.status, got.sum_value, got.product_value);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.sum_value !== want.sum_value) begin
          $error("sum_value: expected %0d, got %0d", want.sum_value, got.sum_value);
          errors++;
        end
        if (got.product_value !== want.product_value) begin
          $error("product_value: expected %0d, got %0d",
                 want.product_value, got.product_value);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  stim_row_t directed[$];

  initial begin
    logic [SIZE_W-1:0] sizes[6];
    sizes = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd5, 4'd8};
    a_len = 0;
    b_len = 0;
    busy_cycles = 0;
    size_reg = SIZE_RESET;
    foreach (sum_mem[k]) begin
      sum_mem[k]  = '0;
      prod_mem[k] = '0;
    end
    // stores are zero after reset, spare actions return all zero
    directed = '{
      '{ACT_READ,     3'd0, 3'd0, 16'h0000, 1, '{STAT_OK, 24'sd0, 44'sd0}},
      '{ACT_READ,     3'd7, 3'd7, 16'h0000, 1, '{STAT_OK, 24'sd0, 44'sd0}},
      '{ACT_SPARE_LO, 3'd7, 3'd7, 16'hffff, 1, '{STAT_OK, 24'sd0, 44'sd0}},
      '{ACT_SPARE_HI, 3'd0, 3'd0, 16'h8000, 1, '{STAT_OK, 24'sd0, 44'sd0}},
      '{ACT_LOAD_A,   3'd0, 3'd0, 16'h7fff, 1, '{STAT_OK, 24'sd0, 44'sd0}},
      '{ACT_LOAD_A,   3'd7, 3'd7, 16'h8000, 1, '{STAT_OK, 24'sd0, 44'sd0}},
      '{ACT_LOAD_A,   3'd7, 3'd0, 16'h0001, 0, '0},
      '{ACT_LOAD_A,   3'd3, 3'd3, 16'h0000, 1, '{STAT_OK, 24'sd0, 44'sd0}},
      '{ACT_LOAD_B,   3'd0, 3'd0, 16'h8000, 1, '{STAT_OK, 24'sd0, 44'sd0}},
      '{ACT_LOAD_B,   3'd7, 3'd7, 16'h7fff, 1, '{STAT_OK, 24'sd0, 44'sd0}},
      '{ACT_LOAD_B,   3'd0, 3'd7, 16'hffff, 0, '0},
      '{ACT_LOAD_B,   3'd0, 3'd0, 16'h8000, 0, '0},
      '{ACT_COMPUTE,  3'd5, 3'd2, 16'h1234, 1, '{STAT_OK, 24'sd0, 44'sd0}},
      '{ACT_READ,     3'd0, 3'd0, 16'h0000, 0, '0},
      '{ACT_READ,     3'd7, 3'd7, 16'h0000, 0, '0},
      '{ACT_READ,     3'd7, 3'd7, 16'hffff, 0, '0},
      '{ACT_READ,     3'd0, 3'd7, 16'h0000, 0, '0},
      '{ACT_READ,     3'd3, 3'd3, 16'h0000, 0, '0},
      '{ACT_CLEAR,    3'd0, 3'd0, 16'h0000, 1, '{STAT_OK, 24'sd0, 44'sd0}},
      // clearing the lists keeps the stores
      '{ACT_READ,     3'd0, 3'd0, 16'h0000, 0, '0},
      '{ACT_COMPUTE,  3'd0, 3'd0, 16'h0000, 1, '{STAT_OK, 24'sd0, 44'sd0}},
      '{ACT_READ,     3'd0, 3'd0, 16'h0000, 1, '{STAT_OK, 24'sd0, 44'sd0}}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_size(SIZE_RESET);
    foreach (directed[k])
      send_request(directed[k].act, directed[k].r, directed[k].c, directed[k].v,
                   directed[k].typed, directed[k].res);
    // several size settings, each followed by a random phase
    foreach (sizes[k]) begin
      wait_idle();
      write_size(sizes[k]);
      random_phase(280, sizes[k] == 4'd15 || sizes[k] == 4'd8);
    end
    wait_idle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
